[hdl/spg_pkg.sv]
// Shared types and constants for the sprite priority grid fixer.
package spg_pkg;

  localparam int LVL_W      = 8;
  localparam int PRIO_W     = 3;
  localparam int POS_W      = 10;
  localparam int CALC_W     = 12;
  localparam int CELL_SHIFT = 4;

  localparam logic [LVL_W-1:0]         LVL_EMPTY  = 8'hFF;
  localparam logic [PRIO_W-1:0]        LVL_BYPASS = 3'd4;
  localparam logic signed [CALC_W-1:0] X_OFFSET   = 12'sd64;
  localparam logic signed [CALC_W-1:0] Y_OFFSET   = 12'sd16;
  localparam logic signed [CALC_W-1:0] CELL_ROUND = 12'sd15;

  localparam logic ACT_CLEAR  = 1'b0;
  localparam logic ACT_SPRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DECIDE,
    ST_WRITE,
    ST_OUT
  } spg_state_t;

endpackage

[hdl/sprite_priority_grid_fix.sv]
// Top level of the sprite priority grid fixer: sequencer, rectangle decode and outputs.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-----------------------------------------------
//  input    | in_valid / in_ready   | in_action, in_pos_x_word, in_pos_y_word,
//           |                       | in_size_code
//  result   | out_valid / out_ready | out_fixed_word, out_level_used,
//           |                       | out_level_found, out_lowered
//
// A sprite covering n grid rows passes through n row reads, the read pipeline
// (memory register, row minimum register, accumulate), one decide state, n row
// writes and the result transfer; reads and writes share the row address row_r.
// A bypassed sprite or one whose clipped rectangle is empty goes straight to the result.
// After reset, and after every clear item, the block sweeps all GRID_ROWS rows to 255,
// one row per cycle, and holds in_ready low meanwhile.
// One item is handled at a time: in_ready is high only in the idle state, and a result
// waiting on out_ready stalls the block until its transfer completes.
module sprite_priority_grid_fix #(
  parameter int GRID_COLS = 24,
  parameter int GRID_ROWS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_pos_x_word,
  input  logic [9:0]  in_pos_y_word,
  input  logic [7:0]  in_size_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_fixed_word,
  output logic [2:0]  out_level_used,
  output logic [7:0]  out_level_found,
  output logic        out_lowered
);
  import spg_pkg::*;

  // Column bounds hold 0..GRID_COLS, row bounds 0..GRID_ROWS; memory rows index narrower.
  localparam int COL_W  = $clog2(GRID_COLS + 1);
  localparam int ROW_CW = $clog2(GRID_ROWS + 1);
  localparam int ROW_AW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  localparam logic signed [CALC_W-1:0] COLS_S   = CALC_W'(GRID_COLS);
  localparam logic signed [CALC_W-1:0] ROWS_S   = CALC_W'(GRID_ROWS);
  localparam logic [ROW_CW-1:0]        LAST_ROW = ROW_CW'(GRID_ROWS - 1);

  spg_state_t state_r, state_nxt;

  logic [ROW_CW-1:0] row_r, row_nxt;
  logic [ROW_CW-1:0] y1_r, y1_nxt;
  logic [ROW_CW-1:0] y2_r, y2_nxt;
  logic [COL_W-1:0]  x1_r, x1_nxt;
  logic [COL_W-1:0]  x2_r, x2_nxt;
  logic [15:0]       word_r, word_nxt;
  logic [PRIO_W-1:0] lev_r, lev_nxt;
  logic [LVL_W-1:0]  found_r, found_nxt;
  logic              lowered_r, lowered_nxt;
  logic [LVL_W-1:0]  acc_r, acc_nxt;
  logic              rd_vld_r;

  // Rectangle decode, in cell units, straight from the input ports.
  logic signed [CALC_W-1:0] px, py, x_lo, x_hi, y_lo, y_hi;
  logic signed [CALC_W-1:0] x1c, x2c, y1c, y2c;
  logic                     rect_empty;
  logic                     is_bypass;

  always_comb begin
    px = signed'({{2{in_pos_x_word[POS_W-1]}}, in_pos_x_word[POS_W-1:0]}) - X_OFFSET;
    py = signed'({{2{in_pos_y_word[POS_W-1]}}, in_pos_y_word[POS_W-1:0]}) - Y_OFFSET;
    x_lo = px >>> CELL_SHIFT;
    y_lo = py >>> CELL_SHIFT;
    x_hi = (px + signed'({3'b000, ({1'b0, in_size_code[3:0]} + 5'd1), 4'b0000})
            + CELL_ROUND) >>> CELL_SHIFT;
    y_hi = (py + signed'({3'b000, ({1'b0, in_size_code[7:4]} + 5'd1), 4'b0000})
            + CELL_ROUND) >>> CELL_SHIFT;
    x1c = (x_lo < 0) ? '0 : x_lo;
    y1c = (y_lo < 0) ? '0 : y_lo;
    x2c = (x_hi > COLS_S) ? COLS_S : x_hi;
    y2c = (y_hi > ROWS_S) ? ROWS_S : y_hi;
    rect_empty = (x1c >= x2c) || (y1c >= y2c);
    is_bypass  = (in_pos_x_word[15:13] == LVL_BYPASS);
  end

  // Column enables for the stored rectangle.
  logic [GRID_COLS-1:0] col_mask;
  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      col_mask[c] = (COL_W'(c) >= x1_r) && (COL_W'(c) < x2_r);
    end
  end

  // Grid memory and the shared row minimum unit.
  logic                               ram_we;
  logic [GRID_COLS-1:0]               ram_wmask;
  logic [LVL_W-1:0]                   ram_wdata;
  logic                               rd_issue;
  logic [GRID_COLS-1:0][LVL_W-1:0]    ram_rdata;
  logic                               mn_vld;
  logic [LVL_W-1:0]                   mn_min;

  spg_grid_ram #(
    .COLS (GRID_COLS),
    .ROWS (GRID_ROWS),
    .AW   (ROW_AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (row_r[ROW_AW-1:0]),
    .wmask   (ram_wmask),
    .wdata   (ram_wdata),
    .raddr   (row_r[ROW_AW-1:0]),
    .rdata_r (ram_rdata)
  );

  spg_row_min #(
    .COLS (GRID_COLS)
  ) u_min (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (rd_vld_r),
    .row    (ram_rdata),
    .mask   (col_mask),
    .vld_r  (mn_vld),
    .min_r  (mn_min)
  );

  // Sequencer: next state, datapath updates and memory control.
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    y1_nxt      = y1_r;
    y2_nxt      = y2_r;
    x1_nxt      = x1_r;
    x2_nxt      = x2_r;
    word_nxt    = word_r;
    lev_nxt     = lev_r;
    found_nxt   = found_r;
    lowered_nxt = lowered_r;
    acc_nxt     = acc_r;
    ram_we      = 1'b0;
    ram_wmask   = col_mask;
    ram_wdata   = {{(LVL_W-PRIO_W){1'b0}}, lev_r};
    rd_issue    = 1'b0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;

    // A finished row minimum folds into the running minimum whenever it arrives.
    if (mn_vld && (mn_min < acc_r)) begin
      acc_nxt = mn_min;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wmask = '1;
        ram_wdata = LVL_EMPTY;
        row_nxt   = row_r + 1'b1;
        if (row_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          word_nxt    = in_pos_x_word;
          lev_nxt     = in_pos_x_word[15:13];
          found_nxt   = LVL_EMPTY;
          lowered_nxt = 1'b0;
          acc_nxt     = LVL_EMPTY;
          x1_nxt      = x1c[COL_W-1:0];
          x2_nxt      = x2c[COL_W-1:0];
          y1_nxt      = y1c[ROW_CW-1:0];
          y2_nxt      = y2c[ROW_CW-1:0];
          if (in_action == ACT_CLEAR) begin
            row_nxt   = '0;
            state_nxt = ST_CLEAR;
          end else if (is_bypass || rect_empty) begin
            state_nxt = ST_OUT;
          end else begin
            row_nxt   = y1c[ROW_CW-1:0];
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_issue = 1'b1;
        row_nxt  = row_r + 1'b1;
        if (row_r + 1'b1 == y2_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !mn_vld) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        found_nxt = acc_r;
        if ({{(LVL_W-PRIO_W){1'b0}}, lev_r} > acc_r) begin
          lev_nxt     = acc_r[PRIO_W-1:0];
          lowered_nxt = 1'b1;
        end
        row_nxt   = y1_r;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we  = 1'b1;
        row_nxt = row_r + 1'b1;
        if (row_r + 1'b1 == y2_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      row_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      rd_vld_r <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    y1_r      <= y1_nxt;
    y2_r      <= y2_nxt;
    x1_r      <= x1_nxt;
    x2_r      <= x2_nxt;
    word_r    <= word_nxt;
    lev_r     <= lev_nxt;
    found_r   <= found_nxt;
    lowered_r <= lowered_nxt;
    acc_r     <= acc_nxt;
  end

  assign out_fixed_word  = {lev_r, word_r[12:0]};
  assign out_level_used  = lev_r;
  assign out_level_found = found_r;
  assign out_lowered     = lowered_r;

  // A lowered priority always equals the minimum found in the rectangle.
  a_lowered_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lowered |-> out_level_found == {5'b00000, out_level_used})
    else $error("lowered level differs from the found minimum");

  // The read pipeline is empty before any rectangle write starts.
  a_drained_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |-> !rd_vld_r && !mn_vld)
    else $error("row write while reads are still in flight");

  // Writes and reads of the grid never share a cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && rd_issue))
    else $error("grid read and write in the same cycle");

  // Every row address used for a memory access lies inside the grid.
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we || rd_issue |-> row_r <= LAST_ROW)
    else $error("grid row address out of range");

  // A waiting result keeps the input side closed.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open while a result waits");

endmodule

[hdl/spg_grid_ram.sv]
// Row-wide grid memory with one cell enable per column and a registered read port.
module spg_grid_ram #(
  parameter int COLS = 24,
  parameter int ROWS = 14,
  parameter int AW   = 4
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        waddr,
  input  logic [COLS-1:0]                      wmask,
  input  logic [spg_pkg::LVL_W-1:0]            wdata,
  input  logic [AW-1:0]                        raddr,
  output logic [COLS-1:0][spg_pkg::LVL_W-1:0]  rdata_r
);
  import spg_pkg::*;

  logic [COLS-1:0][LVL_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    for (int c = 0; c < COLS; c++) begin
      if (we && wmask[c]) begin
        mem[waddr][c] <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

[hdl/spg_row_min.sv]
// Masked minimum over one grid row through a compare tree, result registered.
module spg_row_min #(
  parameter int COLS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  logic [COLS-1:0][spg_pkg::LVL_W-1:0]  row,
  input  logic [COLS-1:0]                      mask,
  output logic                                 vld_r,
  output logic [spg_pkg::LVL_W-1:0]            min_r
);
  import spg_pkg::*;

  localparam int LEAVES = 1 << $clog2(COLS);

  logic [LVL_W-1:0] node [2*LEAVES-1];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < COLS) begin : g_used
      assign node[LEAVES-1+i] = mask[i] ? row[i] : LVL_EMPTY;
    end else begin : g_pad
      assign node[LEAVES-1+i] = LVL_EMPTY;
    end
  end

  for (genvar i = 0; i < LEAVES-1; i++) begin : g_node
    assign node[i] = (node[2*i+1] < node[2*i+2]) ? node[2*i+1] : node[2*i+2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= node[0];
  end

endmodule

[sim/sprite_priority_grid_fix_test.sv]
// Self-checking testbench for the sprite priority grid fixer: directed table, random frames.
module sprite_priority_grid_fix_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spg_pkg::*;

  localparam int GRID_COLS   = 24;
  localparam int GRID_ROWS   = 14;
  localparam int CELL_COUNT  = GRID_COLS * GRID_ROWS;
  localparam int SPRITE_GOAL = 800;
  // Long enough for the single item in flight to finish and park on out_valid,
  // so that in_ready stays low while the sender keeps offering.
  localparam int LONG_HOLD   = 400;
  // Covers the worst sprite and a clear sweep of all 14 rows, with plenty of slack.
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PRINT_LIMIT   = 40;

  // One result transfer, field by field.
  typedef struct packed {
    logic [15:0] fixed_word;
    logic [2:0]  level_used;
    logic [7:0]  level_found;
    logic        lowered;
  } fix_result_t;

  // One row of the directed table. Where has_want is set, the expected result is
  // typed into the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic        action;
    logic [15:0] word;
    logic [9:0]  ypos;
    logic [7:0]  size;
    logic        has_want;
    fix_result_t want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = ACT_CLEAR;
  logic [15:0] in_pos_x_word = '0;
  logic [9:0]  in_pos_y_word = '0;
  logic [7:0]  in_size_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_fixed_word;
  logic [2:0]  out_level_used;
  logic [7:0]  out_level_found;
  logic        out_lowered;

  // Travel with the payload so that the scoreboard sees them at the same edge.
  logic        row_has_want = 1'b0;
  fix_result_t row_want = '0;

  // Our own copy of the priority grid, row-major, one level per cell.
  logic [7:0]  grid_level [CELL_COUNT];

  // Expected results in the order the block must return them.
  fix_result_t fix_q [$];
  table_row_t  directed_rows [$];

  int  mismatch_count = 0;
  bit  long_hold_req = 1'b0;
  bit  send_burst = 1'b0;
  bit  take_burst = 1'b0;

  sprite_priority_grid_fix #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_pos_x_word  (in_pos_x_word),
    .in_pos_y_word  (in_pos_y_word),
    .in_size_code   (in_size_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_fixed_word (out_fixed_word),
    .out_level_used (out_level_used),
    .out_level_found(out_level_found),
    .out_lowered    (out_lowered)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The run must finish well inside this; reaching it means the block hung.
  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Both reset and a clear item leave every cell at the empty level.
  task automatic fill_grid_empty();
    for (int i = 0; i < CELL_COUNT; i++) begin
      grid_level[i] = LVL_EMPTY;
    end
  endtask

  // Works out the result of one sprite and applies its write to the grid copy.
  // Low edges are floored, high edges rounded up, into 16-pixel cells by an arithmetic
  // shift, which rounds toward minus infinity for the negative positions near the edges.
  function automatic fix_result_t predict_fix(input logic [15:0] word,
                                              input logic [9:0] ypos,
                                              input logic [7:0] size);
    fix_result_t r;
    logic [2:0]  lvl;
    logic [7:0]  lowest;
    int          px, py, c0, c1, r0, r1;
    lvl           = word[15:13];
    r.fixed_word  = word;
    r.level_used  = lvl;
    r.level_found = LVL_EMPTY;
    r.lowered     = 1'b0;
    // The bypass level never touches the grid.
    if (lvl == LVL_BYPASS) begin
      return r;
    end
    px = $signed(word[POS_W-1:0]) - int'(X_OFFSET);
    py = $signed(ypos) - int'(Y_OFFSET);
    c0 = px >>> CELL_SHIFT;
    r0 = py >>> CELL_SHIFT;
    c1 = (px + ((int'(size[3:0]) + 1) << CELL_SHIFT) + int'(CELL_ROUND)) >>> CELL_SHIFT;
    r1 = (py + ((int'(size[7:4]) + 1) << CELL_SHIFT) + int'(CELL_ROUND)) >>> CELL_SHIFT;
    if (c0 < 0) c0 = 0;
    if (r0 < 0) r0 = 0;
    if (c1 > GRID_COLS) c1 = GRID_COLS;
    if (r1 > GRID_ROWS) r1 = GRID_ROWS;
    // An empty clipped rectangle leaves lowest at the empty level and writes nothing.
    lowest = LVL_EMPTY;
    for (int cy = r0; cy < r1; cy++) begin
      for (int cx = c0; cx < c1; cx++) begin
        if (grid_level[cy*GRID_COLS + cx] < lowest) lowest = grid_level[cy*GRID_COLS + cx];
      end
    end
    if ({5'd0, lvl} > lowest) begin
      lvl       = lowest[2:0];
      r.lowered = 1'b1;
    end
    for (int cy = r0; cy < r1; cy++) begin
      for (int cx = c0; cx < c1; cx++) begin
        grid_level[cy*GRID_COLS + cx] = {5'd0, lvl};
      end
    end
    r.fixed_word  = {lvl, word[12:0]};
    r.level_used  = lvl;
    r.level_found = lowest;
    return r;
  endfunction

  // Scoreboard. Everything here is sampled at the rising edge, so it sees the
  // values that were stable before the edge, for both our drives and the block's.
  always @(posedge clk) begin : scoreboard
    fix_result_t predicted;
    fix_result_t want;
    if (!rst_n) begin
      fill_grid_empty();
    end else begin
      if (in_valid && in_ready) begin
        if (in_action == ACT_CLEAR) begin
          fill_grid_empty();
        end else begin
          predicted = predict_fix(in_pos_x_word, in_pos_y_word, in_size_code);
          fix_q.push_back(row_has_want ? row_want : predicted);
        end
      end
      if (out_valid && out_ready) begin
        if (fix_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected, word %h",
                                    out_fixed_word));
        end else begin
          want = fix_q.pop_front();
          if (out_fixed_word !== want.fixed_word)
            report_mismatch($sformatf("fixed_word %h, expected %h",
                                      out_fixed_word, want.fixed_word));
          if (out_level_used !== want.level_used)
            report_mismatch($sformatf("level_used %0d, expected %0d",
                                      out_level_used, want.level_used));
          if (out_level_found !== want.level_found)
            report_mismatch($sformatf("level_found %0d, expected %0d",
                                      out_level_found, want.level_found));
          if (out_lowered !== want.lowered)
            report_mismatch($sformatf("lowered %0b, expected %0b",
                                      out_lowered, want.lowered));
        end
      end
    end
  end

  // Result side. Each transfer is preceded by a random wait, except in burst
  // stretches. On request it holds out_ready low for a long stretch so that the
  // block keeps its result and stops taking input.
  initial begin : result_sink
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        for (int hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(posedge clk);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offers one item after a random gap and returns at the edge of its transfer.
  // in_valid stays high from one item to the next when no gap is drawn.
  task automatic offer_item(input logic act, input logic [15:0] word, input logic [9:0] ypos,
                            input logic [7:0] size, input logic has_want,
                            input fix_result_t want);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_pos_x_word <= word;
    in_pos_y_word <= ypos;
    in_size_code  <= size;
    row_has_want  <= has_want;
    row_want      <= want;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic add_row(input logic act, input logic [15:0] word, input logic [9:0] ypos,
                         input logic [7:0] size, input logic has_want,
                         input fix_result_t want);
    directed_rows.push_back('{act, word, ypos, size, has_want, want});
  endtask

  initial begin : stimulus
    table_row_t  row;
    int          sprites_sent;
    int          frame_len;
    bit          noisy_frame;
    logic [2:0]  prio;
    logic [9:0]  xw;
    logic [9:0]  yw;
    logic [7:0]  size;
    int          guard;

    // Directed table. Typed expectations sit where the answer is obvious: the
    // grid fresh after reset or a clear, sprites stacked on one cell, the bypass
    // level and empty rectangles. Position words 64 and 16 put the sprite on the top-left cell.
    add_row(ACT_SPRITE, 16'hE040, 10'd16, 8'h00, 1'b1, '{16'hE040, 3'd7, 8'hFF, 1'b0});
    add_row(ACT_SPRITE, 16'hE040, 10'd16, 8'h00, 1'b1, '{16'hE040, 3'd7, 8'd7,  1'b0});
    add_row(ACT_SPRITE, 16'h4040, 10'd16, 8'h00, 1'b1, '{16'h4040, 3'd2, 8'd7,  1'b0});
    // A higher priority over that cell is pulled down to the level already there.
    add_row(ACT_SPRITE, 16'hC040, 10'd16, 8'h00, 1'b1, '{16'h4040, 3'd2, 8'd2,  1'b1});
    // Bypass level with every other bit set, then with every other bit clear.
    add_row(ACT_SPRITE, 16'h9FFF, 10'h3FF, 8'hFF, 1'b1, '{16'h9FFF, 3'd4, 8'hFF, 1'b0});
    add_row(ACT_SPRITE, 16'h8000, 10'h000, 8'h00, 1'b1, '{16'h8000, 3'd4, 8'hFF, 1'b0});
    // Empty rectangles: far right, far left and below the grid.
    add_row(ACT_SPRITE, 16'h01FF, 10'd16,  8'h00, 1'b1, '{16'h01FF, 3'd0, 8'hFF, 1'b0});
    add_row(ACT_SPRITE, 16'hA200, 10'd16,  8'h00, 1'b1, '{16'hA200, 3'd5, 8'hFF, 1'b0});
    add_row(ACT_SPRITE, 16'h2040, 10'h1FF, 8'h00, 1'b1, '{16'h2040, 3'd1, 8'hFF, 1'b0});
    // Largest size from the most negative and from the origin, then widest and tallest only.
    add_row(ACT_SPRITE, 16'hE200, 10'h200, 8'hFF, 1'b0, '0);
    add_row(ACT_SPRITE, 16'hE000, 10'h000, 8'hFF, 1'b0, '0);
    add_row(ACT_SPRITE, 16'h7C46, 10'd20,  8'h0F, 1'b0, '0);
    add_row(ACT_SPRITE, 16'h1DBF, 10'd230, 8'hF0, 1'b0, '0);
    // A clear with all payload bits set must only reset the grid.
    add_row(ACT_CLEAR,  16'hFFFF, 10'h3FF, 8'hFF, 1'b0, '0);
    add_row(ACT_SPRITE, 16'h6040, 10'd16,  8'h00, 1'b1, '{16'h6040, 3'd3, 8'hFF, 1'b0});
    // Overlapping sprites at unaligned positions, reaching past the right, bottom, left and top.
    add_row(ACT_SPRITE, 16'h0070, 10'd25,  8'h33, 1'b0, '0);
    add_row(ACT_SPRITE, 16'hE0A0, 10'd40,  8'h55, 1'b0, '0);
    add_row(ACT_SPRITE, 16'hA1A5, 10'd200, 8'h7A, 1'b0, '0);
    add_row(ACT_SPRITE, 16'hC1BF, 10'd239, 8'hFF, 1'b0, '0);
    add_row(ACT_SPRITE, 16'h5C3F, 10'h3F0, 8'h21, 1'b0, '0);
    add_row(ACT_CLEAR,  16'h0000, 10'h000, 8'h00, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_item(row.action, row.word, row.ypos, row.size, row.has_want, row.want);
    end

    // Random frames: a clear, then a sprite list. Most frames keep the sprites
    // around the visible area so that rectangles overlap and levels get lowered;
    // some frames are pure noise over the whole position and size range.
    sprites_sent = 0;
    while (sprites_sent < SPRITE_GOAL) begin
      offer_item(ACT_CLEAR, 16'($urandom()), 10'($urandom()), 8'($urandom()), 1'b0, '0);
      frame_len   = $urandom_range(3, 40);
      noisy_frame = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < frame_len && sprites_sent < SPRITE_GOAL; k++) begin
        prio = 3'($urandom_range(0, 7));
        if (noisy_frame || $urandom_range(0, 9) == 0) begin
          xw   = 10'($urandom());
          yw   = 10'($urandom());
          size = 8'($urandom());
        end else begin
          xw   = 10'($urandom_range(0, 460));
          yw   = 10'($urandom_range(0, 250));
          size = ($urandom_range(0, 3) == 0) ? 8'($urandom()) :
                 {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
        end
        offer_item(ACT_SPRITE, {prio, 3'($urandom_range(0, 7)), xw}, yw, size, 1'b0, '0);
        sprites_sent++;
        // Long stall on the result side while we keep offering.
        if (sprites_sent == 150) long_hold_req = 1'b1;
        // Let the block run completely dry once before going on.
        if (sprites_sent == 420) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (fix_q.size() != 0);
        end
      end
    end
    in_valid <= 1'b0;

    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (fix_q.size() != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fix_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", fix_q.size()));
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
